// ===== hw/rtl/srd_pkg.sv =====
// shared types and constants for the sprite scanline decoder
`timescale 1ns / 1ps

package srd_pkg;

  localparam int BYTE_W                = 8;
  localparam int RUN_W                 = 7;
  localparam int WRITE_INDEX_W         = 26;
  localparam int CFG_W                 = 14;
  localparam int CFG_IDX_W             = 2;
  localparam int DEFAULT_MAX_CELL_SIDE = 8192;
  localparam int DEFAULT_QUEUE_DEPTH   = 4;
  localparam int DEFAULT_SIDE          = 64;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_MODE = 2'd2;

  localparam logic [BYTE_W-1:0] SHADOW_INDEX      = 8'd47;
  localparam logic [BYTE_W-1:0] OPAQUE_COUNT_MASK = 8'h7f;

  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] count_full;
    logic [RUN_W-1:0]  count_opaque;
    logic              count_opaque_zero;
    logic [BYTE_W-1:0] pixel_value;
  } srd_entry_t;

endpackage

// ===== hw/rtl/srd_if.sv =====
// handshake channels for compressed bytes and pixel writes
`timescale 1ns / 1ps

interface srd_in_if import srd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] src_byte;
  logic              start_of_picture;

  modport source (output valid, output src_byte, output start_of_picture, input ready);
  modport sink   (input valid, input src_byte, input start_of_picture, output ready);
endinterface

interface srd_out_if import srd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [WRITE_INDEX_W-1:0] write_index;
  logic [BYTE_W-1:0]        write_value;

  modport source (output valid, output write_index, output write_value, input ready);
  modport sink   (input valid, input write_index, input write_value, output ready);
endinterface

// ===== hw/rtl/srd_front.sv =====
// input side: takes bytes and precomputes run counts and pixel value
`timescale 1ns / 1ps

module srd_front import srd_pkg::*; (
  srd_in_if.sink     src,
  input  logic       shadow_mode,
  input  logic       queue_full,
  output logic       push,
  output srd_entry_t entry
);

  logic [BYTE_W-1:0] masked;

  assign src.ready = !queue_full;
  assign push      = src.valid && !queue_full;

  assign masked = src.src_byte & OPAQUE_COUNT_MASK;

  always_comb begin
    entry.start             = src.start_of_picture;
    entry.count_full        = src.src_byte;
    entry.count_opaque      = masked[RUN_W-1:0];
    entry.count_opaque_zero = (masked == '0);
    // shadow pixels all collapse to one palette entry
    entry.pixel_value       = shadow_mode ? SHADOW_INDEX : src.src_byte;
  end

endmodule

// ===== hw/rtl/srd_queue.sv =====
// short queue between the front and the decode stage
`timescale 1ns / 1ps

module srd_queue import srd_pkg::*; #(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  srd_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output srd_entry_t head,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  srd_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/srd_back.sv =====
// decode stage: row, column and run state, output register
`timescale 1ns / 1ps

module srd_back import srd_pkg::*; #(
  parameter int SIDE_W = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SIDE_W-1:0]   cell_w,
  input  logic [SIDE_W-1:0]   cell_h,
  input  logic [2*SIDE_W-1:0] cell_area,
  input  logic                queue_empty,
  input  srd_entry_t          head,
  output logic                pop,
  srd_out_if.source           dst
);

  localparam int AREA_W = 2 * SIDE_W;
  localparam int IDX_W  = AREA_W + 1;
  localparam int SUM_W  = ((SIDE_W > BYTE_W) ? SIDE_W : BYTE_W) + 1;

  logic [SIDE_W-1:0] row_number;
  logic [AREA_W-1:0] row_base_index;
  logic [SIDE_W-1:0] column_position;
  logic              run_is_opaque;
  logic              copying_pixels;
  logic [RUN_W-1:0]  run_length;
  logic [RUN_W-1:0]  run_offset;
  logic              picture_done;

  logic [SIDE_W-1:0] row_number_next;
  logic [AREA_W-1:0] row_base_index_next;
  logic [SIDE_W-1:0] column_position_next;
  logic              run_is_opaque_next;
  logic              copying_pixels_next;
  logic [RUN_W-1:0]  run_length_next;
  logic [RUN_W-1:0]  run_offset_next;
  logic              picture_done_next;

  logic              end_run;
  logic [BYTE_W-1:0] end_count;
  logic [SUM_W-1:0]  col_sum;
  logic [RUN_W:0]    offset_inc;
  logic [IDX_W-1:0]  pixel_index;
  logic              emit;

  logic              out_valid;
  logic [IDX_W-1:0]  out_index;
  logic [BYTE_W-1:0] out_value;

  assign pop = !queue_empty && (!out_valid || dst.ready);

  always_comb begin
    row_number_next      = row_number;
    row_base_index_next  = row_base_index;
    column_position_next = column_position;
    run_is_opaque_next   = run_is_opaque;
    copying_pixels_next  = copying_pixels;
    run_length_next      = run_length;
    run_offset_next      = run_offset;
    picture_done_next    = picture_done;
    end_run              = 1'b0;
    end_count            = '0;
    emit                 = 1'b0;
    col_sum              = '0;

    if (head.start) begin
      row_number_next      = '0;
      row_base_index_next  = '0;
      column_position_next = '0;
      run_is_opaque_next   = 1'b0;
      copying_pixels_next  = 1'b0;
      run_length_next      = '0;
      run_offset_next      = '0;
      picture_done_next    = 1'b0;
    end

    pixel_index = IDX_W'(row_base_index_next) + IDX_W'(column_position_next)
                + IDX_W'(run_offset_next);
    offset_inc  = {1'b0, run_offset_next} + 1'b1;

    if (!(cell_w == '0 || cell_h == '0 || picture_done_next || row_number_next >= cell_h)) begin
      if (copying_pixels_next) begin
        emit = (pixel_index < {1'b0, cell_area});
        if (offset_inc >= {1'b0, run_length_next}) begin
          end_run   = 1'b1;
          end_count = BYTE_W'(run_length_next);
        end else begin
          run_offset_next = offset_inc[RUN_W-1:0];
        end
      end else if (!run_is_opaque_next) begin
        end_run   = 1'b1;
        end_count = head.count_full;
      end else if (head.count_opaque_zero) begin
        end_run   = 1'b1;
        end_count = '0;
      end else begin
        copying_pixels_next = 1'b1;
        run_length_next     = head.count_opaque;
        run_offset_next     = '0;
      end
    end

    if (end_run) begin
      col_sum             = SUM_W'(column_position_next) + SUM_W'(end_count);
      copying_pixels_next = 1'b0;
      run_length_next     = '0;
      run_offset_next     = '0;
      // a run that reaches the width closes the scanline
      if (col_sum >= SUM_W'(cell_w)) begin
        row_number_next      = row_number_next + 1'b1;
        row_base_index_next  = row_base_index_next + AREA_W'(cell_w);
        column_position_next = '0;
        run_is_opaque_next   = 1'b0;
        if (row_number_next >= cell_h) begin
          picture_done_next = 1'b1;
        end
      end else begin
        column_position_next = col_sum[SIDE_W-1:0];
        run_is_opaque_next   = !run_is_opaque_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_number      <= '0;
      row_base_index  <= '0;
      column_position <= '0;
      run_is_opaque   <= 1'b0;
      copying_pixels  <= 1'b0;
      run_length      <= '0;
      run_offset      <= '0;
      picture_done    <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        row_number      <= row_number_next;
        row_base_index  <= row_base_index_next;
        column_position <= column_position_next;
        run_is_opaque   <= run_is_opaque_next;
        copying_pixels  <= copying_pixels_next;
        run_length      <= run_length_next;
        run_offset      <= run_offset_next;
        picture_done    <= picture_done_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_index <= pixel_index;
      out_value <= head.pixel_value;
    end
  end

  assign dst.valid       = out_valid;
  assign dst.write_index = WRITE_INDEX_W'(out_index);
  assign dst.write_value = out_value;

  // a waiting transaction must block the decode stage
  assert property (@(posedge clk) disable iff (rst) (out_valid && !dst.ready) |-> !pop)
    else $error("decode stage advanced while a result was stalled");

  assert property (@(posedge clk) disable iff (rst) (pop && emit) |=> out_valid)
    else $error("pixel write lost");

  assert property (@(posedge clk) disable iff (rst)
    copying_pixels |-> (run_length != '0 && run_offset < run_length))
    else $error("copy run counters out of range");

  assert property (@(posedge clk) disable iff (rst)
    !copying_pixels |-> (run_offset == '0 && run_length == '0))
    else $error("run counters not cleared outside a copy run");

  assert property (@(posedge clk) disable iff (rst) picture_done |-> !copying_pixels)
    else $error("copy run active after the last scanline");

endmodule

// ===== hw/rtl/sprite_scanline_rle_decoder_unit.sv =====
// top level of the sprite scanline run-length decoder
`timescale 1ns / 1ps
//
// Compressed sprite bytes enter on src (valid/ready, one byte per transaction,
// start_of_picture restarts decoding at row 0 before that byte). Pixel writes
// leave on dst as a linear index (row * width + column) and a palette value.
// Each scanline starts with a transparent run (count byte, pixels skipped),
// then alternates with opaque runs (7-bit count, then that many pixel bytes).
// Only bytes that land inside the cell produce a write.
// cfg_we/cfg_index/cfg_data set width, height and shadow mode; write them only
// while no byte is in flight. Sides above MAX_CELL_SIDE act as MAX_CELL_SIDE.
// Throughput is one byte per cycle unless dst stalls, set by the decode stage's
// state update. An accepted byte waits in the queue; its write is registered
// in the output register as it leaves the queue. A stall on dst holds the
// output register; the queue takes bytes until full, then src.ready drops.
// Reset sets width and height to 64, shadow mode off, empties the queue and
// puts the decoder at row 0 expecting a transparent count.
//
module sprite_scanline_rle_decoder_unit import srd_pkg::*; #(
  parameter int MAX_CELL_SIDE = DEFAULT_MAX_CELL_SIDE,
  parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  srd_in_if.sink               src,
  srd_out_if.source            dst
);

  localparam int SIDE_W   = $clog2(MAX_CELL_SIDE + 1);
  localparam int AREA_W   = 2 * SIDE_W;
  localparam int RESET_EFF = (DEFAULT_SIDE > MAX_CELL_SIDE) ? MAX_CELL_SIDE : DEFAULT_SIDE;
  localparam logic [CFG_W-1:0]  MAX_V      = CFG_W'(MAX_CELL_SIDE);
  localparam logic [AREA_W-1:0] RESET_AREA = AREA_W'(RESET_EFF * RESET_EFF);

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
    clamp_side = (v > MAX_V) ? SIDE_W'(MAX_V) : SIDE_W'(v);
  endfunction

  logic [CFG_W-1:0]  cell_width;
  logic [CFG_W-1:0]  cell_height;
  logic              shadow_mode;
  logic [AREA_W-1:0] cell_area;
  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;

  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  srd_entry_t push_entry;
  srd_entry_t head;

  assign w_eff = clamp_side(cell_width);
  assign h_eff = clamp_side(cell_height);

  // the area is refreshed with each side write so it is ready for the next byte
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width  <= CFG_W'(DEFAULT_SIDE);
      cell_height <= CFG_W'(DEFAULT_SIDE);
      shadow_mode <= 1'b0;
      cell_area   <= RESET_AREA;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELL_WIDTH: begin
          cell_width <= cfg_data;
          cell_area  <= AREA_W'(clamp_side(cfg_data)) * AREA_W'(h_eff);
        end
        REG_CELL_HEIGHT: begin
          cell_height <= cfg_data;
          cell_area   <= AREA_W'(w_eff) * AREA_W'(clamp_side(cfg_data));
        end
        REG_SHADOW_MODE: begin
          shadow_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  srd_front u_front (
    .src         (src),
    .shadow_mode (shadow_mode),
    .queue_full  (queue_full),
    .push        (push),
    .entry       (push_entry)
  );

  srd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty)
  );

  srd_back #(
    .SIDE_W (SIDE_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cell_w      (w_eff),
    .cell_h      (h_eff),
    .cell_area   (cell_area),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .dst         (dst)
  );

endmodule
